/* hw/rtl/frame_diff_motion_row_mask_unit_macros.svh */
// Assertion helpers; they expect clk and arst_n in scope.
`ifndef FRAME_DIFF_MOTION_ROW_MASK_UNIT_MACROS_SVH
`define FRAME_DIFF_MOTION_ROW_MASK_UNIT_MACROS_SVH

`define FDM_ASSERT_NOW(label, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error(msg);

`define FDM_ASSERT_NEXT(label, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error(msg);

`endif

/* hw/rtl/fdm_pkg.sv */
package fdm_pkg;

	typedef struct packed {
		logic       drain;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic       row_end;
		logic       frame_end;
	} result_t;

	typedef struct packed {
		logic pix;
		logic emit;
		logic seen;
		logic bank;
		logic em_bank;
		logic row_end;
		logic frame_end;
	} ctl_t;

	localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_THRESHOLD    = 2'd2;

	localparam logic [10:0] WIDTH_RESET     = 11'd640;
	localparam logic [9:0]  HEIGHT_RESET    = 10'd480;
	localparam logic [7:0]  THRESHOLD_RESET = 8'd33;

	localparam int QDEPTH = 8;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic [12:0] WEIGHT_R = 13'd4899;
	localparam logic [13:0] WEIGHT_G = 14'd9617;
	localparam logic [10:0] WEIGHT_B = 11'd1868;
	localparam logic [21:0] ROUND    = 22'd8192;

endpackage

/* hw/rtl/frame_diff_motion_row_mask_unit.sv */
// Channel   Handshake            Payload
// pixel     push / full          drain, blue, green, red
// result    empty / pop          out_blue, out_green, out_red, row_end, frame_end
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pixel per clock sustained while full is low; a result reaches the queue
// through the multiply, frame-store read and difference stages.
// full rises when the eight-entry result queue plus results in flight fill it.
// Reset clears counters and motion state; the frame and row stores are not cleared.
`include "frame_diff_motion_row_mask_unit_macros.svh"
module frame_diff_motion_row_mask_unit import fdm_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  pixel_t      pixel,
	output logic        empty,
	input  logic        pop,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [10:0]      width_q;
	logic [9:0]       height_q;
	logic [7:0]       thr_q;
	logic [CW-1:0]    wlast, col, em_col;
	logic [RW-1:0]    hlast;
	logic [RW+CW-1:0] addr;
	ctl_t             ctl;
	logic             take, q_push;
	result_t          q_data;
	logic [1:0]       inflight;
	logic [QCW-1:0]   q_cnt;
	logic [QCW:0]     credit;

	assign cfg_ready = 1'b1;
	assign take      = push && !full;
	assign credit    = {1'b0, q_cnt} + (QCW + 1)'(inflight);
	assign full      = credit >= (QCW + 1)'(QDEPTH);

	always_comb begin
		if (width_q == '0) begin
			wlast = '0;
		end else if (32'(width_q) > MAX_WIDTH) begin
			wlast = CW'(MAX_WIDTH - 1);
		end else begin
			wlast = CW'(width_q - 11'd1);
		end
		if (height_q == '0) begin
			hlast = '0;
		end else if (32'(height_q) > MAX_HEIGHT) begin
			hlast = RW'(MAX_HEIGHT - 1);
		end else begin
			hlast = RW'(height_q - 10'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			thr_q    <= THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: height_q <= cfg_data[9:0];
				CFG_THRESHOLD:    thr_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	fdm_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (pixel),
		.wlast  (wlast),
		.hlast  (hlast),
		.ctl    (ctl),
		.col    (col),
		.em_col (em_col),
		.addr   (addr)
	);

	fdm_pixel_pipe #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.ctl       (ctl),
		.item      (pixel),
		.col       (col),
		.em_col    (em_col),
		.addr      (addr),
		.thr       (thr_q),
		.res_valid (q_push),
		.res       (q_data),
		.inflight  (inflight)
	);

	fdm_result_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.data   (q_data),
		.pop    (pop),
		.head   (result),
		.empty  (empty),
		.count  (q_cnt)
	);

	`FDM_ASSERT_NOW(a_no_overflow, q_push, q_cnt < QCW'(QDEPTH) || (pop && !empty), "result queue overflow")
	`FDM_ASSERT_NOW(a_result_traced, q_push, $past(take && ctl.emit, 3), "result without request")
	`FDM_ASSERT_NOW(a_frame_row_end, !empty && result.frame_end, result.row_end, "frame end off row end")
	`FDM_ASSERT_NEXT(a_drain_empty, pop && !empty && q_cnt == QCW'(1) && !q_push, empty, "queue not empty")

endmodule

/* hw/rtl/fdm_ram.sv */
module fdm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/fdm_front.sv */
module fdm_front import fdm_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 512,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_HEIGHT)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  pixel_t        item,
	input  logic [CW-1:0] wlast,
	input  logic [RW-1:0] hlast,
	output ctl_t          ctl,
	output logic [CW-1:0] col,
	output logic [CW-1:0] em_col,
	output logic [RW+CW-1:0] addr
);

	logic [CW-1:0] ic_q, oc_q;
	logic [RW-1:0] ir_q, pidx_q, row;
	logic          pend_q, bank_q, seen_q;
	logic          end_row, last_col;

	assign end_row  = ic_q >= wlast;
	assign last_col = oc_q >= wlast;
	assign col      = end_row ? wlast : ic_q;
	assign row      = (ir_q >= hlast) ? hlast : ir_q;
	assign addr     = {row, col};
	assign em_col   = oc_q;

	always_comb begin
		ctl.pix       = ~item.drain;
		ctl.emit      = pend_q;
		ctl.seen      = seen_q;
		ctl.bank      = bank_q;
		ctl.em_bank   = ~bank_q;
		ctl.row_end   = last_col;
		ctl.frame_end = last_col && (pidx_q >= hlast);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ic_q   <= '0;
			ir_q   <= '0;
			oc_q   <= '0;
			pidx_q <= '0;
			pend_q <= 1'b0;
			bank_q <= 1'b0;
			seen_q <= 1'b0;
		end else if (take) begin
			if (pend_q) begin
				if (last_col) begin
					pend_q <= 1'b0;
					oc_q   <= '0;
				end else begin
					oc_q <= oc_q + 1'b1;
				end
			end
			if (!item.drain) begin
				if (end_row) begin
					pend_q <= 1'b1;
					pidx_q <= row;
					oc_q   <= '0;
					bank_q <= ~bank_q;
					ic_q   <= '0;
					if (ir_q >= hlast) begin
						ir_q   <= '0;
						seen_q <= 1'b1;
					end else begin
						ir_q <= ir_q + 1'b1;
					end
				end else begin
					ic_q <= ic_q + 1'b1;
				end
			end
		end
	end

endmodule

/* hw/rtl/fdm_pixel_pipe.sv */
module fdm_pixel_pipe import fdm_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 512,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_HEIGHT)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  ctl_t             ctl,
	input  pixel_t           item,
	input  logic [CW-1:0]    col,
	input  logic [CW-1:0]    em_col,
	input  logic [RW+CW-1:0] addr,
	input  logic [7:0]       thr,
	output logic             res_valid,
	output result_t          res,
	output logic [1:0]       inflight
);

	logic             v_s1, v_s2, v_s3;
	ctl_t             ctl_s1, ctl_s2, ctl_s3;
	pixel_t           px_s1;
	logic [RW+CW-1:0] addr_s1, addr_s2, addr_s3, wl_addr_q;
	logic [CW-1:0]    col_s1, col_s2, col_s3;
	logic [CW-1:0]    emc_s1, emc_s2, emc_s3;
	logic [23:0]      row_rd, row_s2, row_s3;
	logic [21:0]      pr_s2, pg_s2, pb_s2;
	logic [7:0]       prev_rd, gray, fwd, gray_s3, prev_s3, wl_gray_q, diff;
	logic             wl_v_q, wr_s3, motion, keep;
	logic             has_q [2];
	logic [CW-1:0]    first_q [2];
	logic [CW-1:0]    last_q [2];

	fdm_ram #(.WIDTH(24), .DEPTH(2 * (2 ** CW))) u_row_ram (
		.clk   (clk),
		.we    (take && ctl.pix),
		.waddr ({ctl.bank, col}),
		.wdata ({item.blue, item.green, item.red}),
		.raddr ({ctl.em_bank, em_col}),
		.rdata (row_rd)
	);

	fdm_ram #(.WIDTH(8), .DEPTH(2 ** (RW + CW))) u_frame_ram (
		.clk   (clk),
		.we    (wr_s3),
		.waddr (addr_s3),
		.wdata (gray_s3),
		.raddr (addr_s1),
		.rdata (prev_rd)
	);

	assign gray  = 8'((pr_s2 + pg_s2 + pb_s2 + ROUND) >> 14);
	assign wr_s3 = v_s3 && ctl_s3.pix;

	always_comb begin
		priority if (wr_s3 && addr_s3 == addr_s2) begin
			fwd = gray_s3;
		end else if (wl_v_q && wl_addr_q == addr_s2) begin
			fwd = wl_gray_q;
		end else begin
			fwd = prev_rd;
		end
	end

	assign diff   = (gray_s3 > prev_s3) ? gray_s3 - prev_s3 : prev_s3 - gray_s3;
	assign motion = diff > thr;
	assign keep   = has_q[ctl_s3.em_bank] && emc_s3 >= first_q[ctl_s3.em_bank]
		&& emc_s3 <= last_q[ctl_s3.em_bank];

	assign res_valid     = v_s3 && ctl_s3.emit;
	assign res.out_blue  = keep ? row_s3[23:16] : 8'd0;
	assign res.out_green = keep ? row_s3[15:8] : 8'd0;
	assign res.out_red   = keep ? row_s3[7:0] : 8'd0;
	assign res.row_end   = ctl_s3.row_end;
	assign res.frame_end = ctl_s3.frame_end;

	assign inflight = 2'(v_s1 && ctl_s1.emit) + 2'(v_s2 && ctl_s2.emit)
		+ 2'(v_s3 && ctl_s3.emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			wl_v_q     <= 1'b0;
			has_q[0]   <= 1'b0;
			has_q[1]   <= 1'b0;
			first_q[0] <= '0;
			first_q[1] <= '0;
			last_q[0]  <= '0;
			last_q[1]  <= '0;
		end else begin
			v_s1   <= take;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			wl_v_q <= wr_s3;
			if (wr_s3) begin
				if (motion) begin
					if (!has_q[ctl_s3.bank] || col_s3 == '0) begin
						first_q[ctl_s3.bank] <= col_s3;
					end
					has_q[ctl_s3.bank]  <= 1'b1;
					last_q[ctl_s3.bank] <= col_s3;
				end else if (col_s3 == '0) begin
					has_q[ctl_s3.bank] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1    <= ctl;
		px_s1     <= item;
		addr_s1   <= addr;
		col_s1    <= col;
		emc_s1    <= em_col;
		ctl_s2    <= ctl_s1;
		addr_s2   <= addr_s1;
		col_s2    <= col_s1;
		emc_s2    <= emc_s1;
		row_s2    <= row_rd;
		pr_s2     <= 22'(px_s1.red * WEIGHT_R);
		pg_s2     <= 22'(px_s1.green * WEIGHT_G);
		pb_s2     <= 22'(px_s1.blue * WEIGHT_B);
		ctl_s3    <= ctl_s2;
		addr_s3   <= addr_s2;
		col_s3    <= col_s2;
		emc_s3    <= emc_s2;
		row_s3    <= row_s2;
		gray_s3   <= gray;
		prev_s3   <= ctl_s2.seen ? fwd : gray;
		wl_addr_q <= addr_s3;
		wl_gray_q <= gray_s3;
	end

endmodule

/* hw/rtl/fdm_result_queue.sv */
module fdm_result_queue import fdm_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  result_t        data,
	input  logic           pop,
	output result_t        head,
	output logic           empty,
	output logic [QCW-1:0] count
);

	result_t        mem_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QCW-1:0] cnt_q;
	logic           take_out;

	assign take_out = pop && cnt_q != '0;
	assign empty    = cnt_q == '0;
	assign head     = mem_q[rp_q];
	assign count    = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (take_out) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + QCW'(push) - QCW'(take_out);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= data;
		end
	end

endmodule
